FILE: rtl/wbss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbss_pkg: shared types and constants for the byte signature scanner
// Operation codes, beat layouts and parameter defaults.
// ----------------------------------------------------------------------------
package wbss_pkg;

  localparam int unsigned NUM_SIGNATURES_DEF = 8;
  localparam int unsigned MAX_SIG_LEN_DEF    = 32;
  localparam int unsigned ADDRESS_BITS_DEF   = 48;

  // Fixed field widths of the stream beats
  localparam int unsigned SLOT_W     = 3;
  localparam int unsigned POS_W      = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned IN_ADDR_W  = 48;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned S_TDATA_W  = 64;
  localparam int unsigned M_TDATA_W  = 56;

  // Decoupling queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_BYTE    = 2'd0,
    OP_SET_LENGTH   = 2'd1,
    OP_START_REGION = 2'd2,
    OP_SCAN_BYTE    = 2'd3
  } op_e;

endpackage
`default_nettype wire

FILE: rtl/wbss_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbss_front: signature store, byte window and parallel window compare
// Accepts one beat per cycle while the queue is not full, updates state, queues hit vectors.
// ----------------------------------------------------------------------------
module wbss_front import wbss_pkg::*; #(
  parameter int unsigned NUM_SIGNATURES    = NUM_SIGNATURES_DEF,
  parameter int unsigned MAX_SIGNATURE_LEN = MAX_SIG_LEN_DEF,
  parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF,
  localparam int unsigned LW = $clog2(MAX_SIGNATURE_LEN + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire op_e                          in_op_i,
  input  wire logic [SLOT_W-1:0]            in_slot_i,
  input  wire logic [POS_W-1:0]             in_pos_i,
  input  wire logic [BYTE_W-1:0]            in_value_i,
  input  wire logic [IN_ADDR_W-1:0]         in_base_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output logic [NUM_SIGNATURES-1:0]         q_hits_o,
  output logic [ADDRESS_BITS-1:0]           q_addr_o,
  output logic [NUM_SIGNATURES*LW-1:0]      q_lens_o
);

  localparam int unsigned M     = MAX_SIGNATURE_LEN;
  localparam int unsigned WIN_D = MAX_SIGNATURE_LEN - 1;

  logic [BYTE_W-1:0]         sig_q [NUM_SIGNATURES][M];
  logic [LW-1:0]             len_q [NUM_SIGNATURES];
  logic [NUM_SIGNATURES-1:0] found_q;
  logic [BYTE_W-1:0]         win_q [WIN_D];
  logic [LW-1:0]             bir_q;
  logic [ADDRESS_BITS-1:0]   addr_q;

  logic                      accept;
  logic                      is_scan;
  logic [LW-1:0]             len_sat;
  logic [LW-1:0]             bir_inc;
  logic [M*BYTE_W-1:0]       win_all;
  logic [M*BYTE_W-1:0]       rev;
  logic [LW-1:0]             shift   [NUM_SIGNATURES];
  logic [M*BYTE_W-1:0]       aligned [NUM_SIGNATURES];
  logic [NUM_SIGNATURES-1:0] byte_ok_all;
  logic [NUM_SIGNATURES-1:0] hits;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_scan    = (in_op_i == OP_SCAN_BYTE);

  always_comb begin
    len_sat = (in_value_i > BYTE_W'(M)) ? LW'(M) : LW'(in_value_i);
    bir_inc = (bir_q < LW'(M)) ? bir_q + LW'(1) : bir_q;
    // Window with the current byte at distance zero
    win_all[BYTE_W-1:0] = in_value_i;
    for (int j = 1; j < M; j++) begin
      win_all[j*BYTE_W +: BYTE_W] = win_q[j-1];
    end
    // Oldest byte first, so a right shift aligns the window tail to position 0
    for (int i = 0; i < M; i++) begin
      rev[i*BYTE_W +: BYTE_W] = win_all[(M-1-i)*BYTE_W +: BYTE_W];
    end
  end

  always_comb begin
    for (int s = 0; s < NUM_SIGNATURES; s++) begin
      shift[s]       = LW'(M) - len_q[s];
      aligned[s]     = rev >> {shift[s], 3'b000};
      byte_ok_all[s] = 1'b1;
      for (int k = 0; k < M; k++) begin
        if (LW'(k) < len_q[s] && sig_q[s][k] != '0 &&
            sig_q[s][k] != aligned[s][k*BYTE_W +: BYTE_W]) begin
          byte_ok_all[s] = 1'b0;
        end
      end
      hits[s] = is_scan && !found_q[s] && (len_q[s] != '0) &&
                (bir_inc >= len_q[s]) && byte_ok_all[s];
    end
  end

  always_comb begin
    q_push_o = accept && is_scan && (hits != '0);
    q_hits_o = hits;
    q_addr_o = addr_q;
    for (int s = 0; s < NUM_SIGNATURES; s++) begin
      q_lens_o[s*LW +: LW] = len_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SIGNATURES; s++) begin
        len_q[s] <= '0;
        for (int k = 0; k < M; k++) begin
          sig_q[s][k] <= '0;
        end
      end
      for (int j = 0; j < WIN_D; j++) begin
        win_q[j] <= '0;
      end
      found_q <= '0;
      bir_q   <= '0;
      addr_q  <= '0;
    end else if (accept) begin
      unique case (in_op_i)
        OP_LOAD_BYTE: begin
          for (int s = 0; s < NUM_SIGNATURES; s++) begin
            for (int k = 0; k < M; k++) begin
              if (in_slot_i == s && in_pos_i == k) begin
                sig_q[s][k] <= in_value_i;
              end
            end
          end
        end
        OP_SET_LENGTH: begin
          for (int s = 0; s < NUM_SIGNATURES; s++) begin
            if (in_slot_i == s) begin
              len_q[s] <= len_sat;
            end
          end
        end
        OP_START_REGION: begin
          for (int j = 0; j < WIN_D; j++) begin
            win_q[j] <= '0;
          end
          found_q <= '0;
          bir_q   <= '0;
          addr_q  <= ADDRESS_BITS'(in_base_i);
        end
        OP_SCAN_BYTE: begin
          win_q[0] <= in_value_i;
          for (int j = 1; j < WIN_D; j++) begin
            win_q[j] <= win_q[j-1];
          end
          found_q <= found_q | hits;
          bir_q   <= bir_inc;
          addr_q  <= addr_q + ADDRESS_BITS'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wbss_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbss_queue: short FIFO between front and back
// Holds hit vectors with their address and signature lengths.
// ----------------------------------------------------------------------------
module wbss_queue import wbss_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      head_o
);

  logic [WIDTH-1:0]       mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_PTR_W:0]   count_q;

  assign full_o  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QUEUE_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QUEUE_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/wbss_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wbss_back: result serializer
// Emits one beat per hit of the head entry, lowest slot first.
// ----------------------------------------------------------------------------
module wbss_back import wbss_pkg::*; #(
  parameter int unsigned NUM_SIGNATURES    = NUM_SIGNATURES_DEF,
  parameter int unsigned MAX_SIGNATURE_LEN = MAX_SIG_LEN_DEF,
  parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF,
  localparam int unsigned LW    = $clog2(MAX_SIGNATURE_LEN + 1),
  localparam int unsigned ENT_W = NUM_SIGNATURES + ADDRESS_BITS + NUM_SIGNATURES * LW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 head_valid_i,
  input  wire logic [ENT_W-1:0]     head_i,
  output logic                      pop_o,
  output logic                      m_valid_o,
  input  wire logic                 m_ready_i,
  output logic [SLOT_W-1:0]         m_slot_o,
  output logic [IN_ADDR_W-1:0]      m_addr_o,
  output logic                      m_last_o
);

  localparam int unsigned IDX_W = (NUM_SIGNATURES > 1) ? $clog2(NUM_SIGNATURES) : 1;

  logic [NUM_SIGNATURES-1:0]    hits, rem, rest, done_q;
  logic [ADDRESS_BITS-1:0]      base_addr, match_addr;
  logic [NUM_SIGNATURES*LW-1:0] lens;
  logic [IDX_W-1:0]             idx;
  logic [LW-1:0]                sel_len;
  logic                         load, last;
  logic                         m_valid_q;
  logic [SLOT_W-1:0]            slot_q;
  logic [IN_ADDR_W-1:0]         addr_q;
  logic                         last_q;

  assign hits      = head_i[NUM_SIGNATURES-1:0];
  assign base_addr = head_i[NUM_SIGNATURES +: ADDRESS_BITS];
  assign lens      = head_i[NUM_SIGNATURES+ADDRESS_BITS +: NUM_SIGNATURES*LW];

  always_comb begin
    rem = hits & ~done_q;
    idx = '0;
    for (int s = NUM_SIGNATURES - 1; s >= 0; s--) begin
      if (rem[s]) begin
        idx = IDX_W'(s);
      end
    end
    for (int s = 0; s < NUM_SIGNATURES; s++) begin
      rest[s] = rem[s] && (IDX_W'(s) != idx);
    end
    last       = (rest == '0);
    sel_len    = lens[idx*LW +: LW];
    match_addr = base_addr - ADDRESS_BITS'(sel_len) + ADDRESS_BITS'(1);
    load       = head_valid_i && (!m_valid_q || m_ready_i);
    pop_o      = load && last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      done_q    <= '0;
    end else begin
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      if (load) begin
        done_q <= last ? '0 : (done_q | (rem & ~rest));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q <= SLOT_W'(idx);
      addr_q <= IN_ADDR_W'(match_addr);
      last_q <= last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_slot_o  = slot_q;
  assign m_addr_o  = addr_q;
  assign m_last_o  = last_q;

endmodule
`default_nettype wire

FILE: rtl/wildcard_byte_signature_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner: multi-signature byte stream scanner
//
// Input stream (s_axis): tuser carries the operation (load signature byte,
// set signature length, start region, scan data byte), tdata the slot,
// position, value and base address. A beat is taken whenever the queue is not full.
// Signature loads and region starts update state and produce no output.
// A scan beat compares all signatures against the byte window in parallel;
// for each newly found signature one output beat (m_axis) carries the slot
// and the start address of the match, lowest slot first, with tlast on the
// final beat for that input.
// Each result beat passes through the queue and then the output register.
// Throughput: one input beat per cycle while the queue has room; a scan with
// k hits emits k output beats; a two-entry queue lets the input side run ahead.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and tready drops once the queue is full.
// Reset: all signature bytes become wildcards, all lengths zero (nothing can
// match), found flags and the window clear, and the address restarts at 0.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner import wbss_pkg::*; #(
  parameter int unsigned NUM_SIGNATURES    = NUM_SIGNATURES_DEF,
  parameter int unsigned MAX_SIGNATURE_LEN = MAX_SIG_LEN_DEF,
  parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // slot [2:0], position [7:3], value [15:8], base_address [63:16]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // operation [1:0]
  input  wire logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // pattern_slot [2:0], match_address [50:3], zero fill [55:51]
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);

  localparam int unsigned LW    = $clog2(MAX_SIGNATURE_LEN + 1);
  localparam int unsigned ENT_W = NUM_SIGNATURES + ADDRESS_BITS + NUM_SIGNATURES * LW;

  logic                         q_full, q_push, q_pop, q_valid;
  logic [NUM_SIGNATURES-1:0]    q_hits;
  logic [ADDRESS_BITS-1:0]      q_addr;
  logic [NUM_SIGNATURES*LW-1:0] q_lens;
  logic [ENT_W-1:0]             q_in, q_head;
  logic [SLOT_W-1:0]            out_slot;
  logic [IN_ADDR_W-1:0]         out_addr;

  // Front: decode the beat, update signatures and window, find new hits
  wbss_front #(
    .NUM_SIGNATURES    (NUM_SIGNATURES),
    .MAX_SIGNATURE_LEN (MAX_SIGNATURE_LEN),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_op_i    (op_e'(s_axis_tuser_i)),
    .in_slot_i  (s_axis_tdata_i[2:0]),
    .in_pos_i   (s_axis_tdata_i[7:3]),
    .in_value_i (s_axis_tdata_i[15:8]),
    .in_base_i  (s_axis_tdata_i[63:16]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_hits_o   (q_hits),
    .q_addr_o   (q_addr),
    .q_lens_o   (q_lens)
  );

  // Entry layout: hits lowest, then the scan address, then the lengths
  assign q_in = {q_lens, q_addr, q_hits};

  wbss_queue #(
    .WIDTH (ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .pop_i       (q_pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  // Back: one output beat per hit, registered toward the receiver
  wbss_back #(
    .NUM_SIGNATURES    (NUM_SIGNATURES),
    .MAX_SIGNATURE_LEN (MAX_SIGNATURE_LEN),
    .ADDRESS_BITS      (ADDRESS_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_slot_o     (out_slot),
    .m_addr_o     (out_addr),
    .m_last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(M_TDATA_W - SLOT_W - IN_ADDR_W)'(0), out_addr, out_slot};

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the wildcard byte signature scanner
// Drives signature loads, length writes, region starts and data bytes on the
// input stream, keeps a shadow copy of the signature store and byte window,
// and checks every match beat (slot, start address, tlast) in order.
// ----------------------------------------------------------------------------
module testbench;
  import wbss_pkg::*;

  localparam int unsigned SIG_SLOTS    = NUM_SIGNATURES_DEF;
  localparam int unsigned SIG_LEN      = MAX_SIG_LEN_DEF;
  localparam int          ITEMS_TARGET = 270;
  localparam int          STALL_LIMIT  = 1000;  // cycles with no beat on either side
  localparam int          HOLD_CYCLES  = 80;    // long receiver hold-off
  localparam int          TAIL_CYCLES  = 16;    // settle time after the last match
  localparam int          IDLE_PCT     = 23;

  // One match beat as the block reports it
  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [IN_ADDR_W-1:0] addr;
    logic                 last;
  } match_t;

  logic                 clk_i;
  logic                 rst_n;
  logic                 s_valid;
  logic [S_TDATA_W-1:0] s_tdata;
  op_e                  s_tuser;
  logic                 m_ready;
  logic                 s_ready;
  logic                 m_valid;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  // Shadow state of the scanner
  logic [7:0]           sig_byte [SIG_SLOTS][SIG_LEN];
  logic [5:0]           sig_len  [SIG_SLOTS];
  bit                   found    [SIG_SLOTS];
  logic [7:0]           window   [SIG_LEN-1];
  int                   seen;
  logic [IN_ADDR_W-1:0] next_addr;

  // Matches predicted but not yet seen on the output, oldest first
  match_t               due_matches [$];

  int beats_sent;
  int regions_opened;
  int matches_seen;
  int mismatches;
  int hold_left;
  bit no_idle;

  wildcard_byte_signature_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    // slot [2:0], position [7:3], value [15:8], base_address [63:16]
    .s_axis_tdata_i  (s_tdata),
    // operation [1:0]
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    // pattern_slot [2:0], match_address [50:3], zero fill [55:51]
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the shadow state by one accepted beat and queue the matches it
  // causes, lowest slot first, tlast on the final one.
  task automatic predict_matches(input op_e op, input logic [SLOT_W-1:0] slot,
                                 input logic [POS_W-1:0] pos, input logic [7:0] value,
                                 input logic [IN_ADDR_W-1:0] base);
    match_t     batch [SIG_SLOTS];
    int         n_hits;
    int         i;
    int         k;
    int         back;
    bit         hit;
    logic [7:0] want;
    logic [7:0] got;
    n_hits = 0;
    case (op)
      OP_LOAD_BYTE: sig_byte[slot][pos] = value;
      OP_SET_LENGTH: sig_len[slot] = (value > SIG_LEN) ? 6'(SIG_LEN) : 6'(value);
      OP_START_REGION: begin
        for (i = 0; i < SIG_LEN - 1; i++) window[i] = 8'h00;
        for (i = 0; i < SIG_SLOTS; i++) found[i] = 1'b0;
        seen      = 0;
        next_addr = base;
      end
      default: begin
        if (seen < SIG_LEN) seen++;
        for (i = 0; i < SIG_SLOTS; i++) begin
          // zero length never matches; nor does one longer than the region so far
          hit = !found[i] && sig_len[i] != 0 && seen >= sig_len[i];
          for (k = 0; hit && k < sig_len[i]; k++) begin
            back = sig_len[i] - 1 - k;
            got  = (back == 0) ? value : window[back-1];
            want = sig_byte[i][k];
            if (want != 8'h00 && want != got) hit = 1'b0;
          end
          if (hit) begin
            found[i]      = 1'b1;
            batch[n_hits] = '{slot: SLOT_W'(i),
                              addr: next_addr - IN_ADDR_W'(sig_len[i] - 1),
                              last: 1'b0};
            n_hits++;
          end
        end
        if (n_hits > 0) batch[n_hits-1].last = 1'b1;
        for (i = 0; i < n_hits; i++) due_matches = {due_matches, batch[i]};
        for (i = SIG_LEN - 2; i > 0; i--) window[i] = window[i-1];
        window[0] = value;
        next_addr = next_addr + 1'b1;
      end
    endcase
  endtask

  // Offer one beat, idling at random first; return once it is accepted.
  task automatic send_beat(input op_e op, input int slot, input int pos, input int value,
                           input logic [IN_ADDR_W-1:0] base);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {base, 8'(value), POS_W'(pos), SLOT_W'(slot)};
    do @(posedge clk_i); while (!s_ready);
    beats_sent++;
    if (op == OP_START_REGION) regions_opened++;
    predict_matches(op, SLOT_W'(slot), POS_W'(pos), 8'(value), base);
  endtask

  // Drop tvalid and hold the sender until every predicted match has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (due_matches.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [IN_ADDR_W-1:0] rand_addr();
    return IN_ADDR_W'({$urandom(), $urandom()});
  endfunction

  // Scan right after reset: no region opened, so addresses count from zero.
  task automatic test_scan_before_region();
    send_beat(OP_LOAD_BYTE, 0, 0, 8'hAB, '0);
    send_beat(OP_LOAD_BYTE, 0, 1, 8'hCD, '0);
    send_beat(OP_SET_LENGTH, 0, 0, 2, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'hAB, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'hCD, '0);
    wait_drained();
  endtask

  // Trailing wildcard, saturated and zero lengths, field extremes, a match
  // whose start address wraps, and two slots hit by one data byte.
  task automatic test_special_cases();
    send_beat(OP_LOAD_BYTE, 1, 0, 8'h11, '0);
    send_beat(OP_LOAD_BYTE, 1, 1, 8'h00, '0);
    send_beat(OP_SET_LENGTH, 1, 0, 2, '0);
    send_beat(OP_SET_LENGTH, 2, 0, 8'hFF, '0);
    send_beat(OP_SET_LENGTH, 3, 0, 0, '0);
    send_beat(OP_LOAD_BYTE, 7, 31, 8'hFF, '0);
    send_beat(OP_SET_LENGTH, 7, 0, SIG_LEN, '0);
    send_beat(OP_LOAD_BYTE, 4, 0, 8'hCD, '0);
    send_beat(OP_SET_LENGTH, 4, 0, 1, '0);
    send_beat(OP_START_REGION, 0, 0, 0, {IN_ADDR_W{1'b1}} - 1'b1);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'hFF, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'h11, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'h00, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'hAB, '0);
    send_beat(OP_SCAN_BYTE, 0, 0, 8'hCD, '0);
    wait_drained();
  endtask

  // Every slot a one-byte wildcard, so each region's first byte hits all
  // eight. Hold the receiver off so the block fills and stalls its input.
  task automatic test_backpressure();
    int s;
    for (s = 0; s < SIG_SLOTS; s++) begin
      send_beat(OP_LOAD_BYTE, s, 0, 8'h00, '0);
      send_beat(OP_SET_LENGTH, s, 0, 1, '0);
    end
    wait_drained();
    hold_left = HOLD_CYCLES;
    repeat (6) begin
      send_beat(OP_START_REGION, 0, 0, 0, rand_addr());
      send_beat(OP_SCAN_BYTE, 0, 0, $urandom_range(255), '0);
    end
    wait_drained();
  endtask

  // Phases of: program a few signatures, open a region, scan a run of bytes
  // from a small alphabet so matches are common, with noise mixed in.
  task automatic test_random_regions();
    int phase;
    int slot;
    int len;
    int k;
    int n_scan;
    int roll;
    int value;
    logic [IN_ADDR_W-1:0] base;
    phase = 0;
    while (beats_sent < ITEMS_TARGET) begin
      phase++;
      no_idle = (phase == 3 || phase == 4);
      repeat ($urandom_range(1, 3)) begin
        slot = $urandom_range(SIG_SLOTS - 1);
        roll = $urandom_range(99);
        if (roll < 70) len = $urandom_range(1, 4);
        else if (roll < 85) len = $urandom_range(5, SIG_LEN);
        else if (roll < 93) len = 0;
        else len = $urandom_range(SIG_LEN + 1, 255);
        send_beat(OP_SET_LENGTH, slot, 0, len, rand_addr());
        // long signatures get only a few bytes, the rest keep old contents
        for (k = 0; k < len && k < SIG_LEN; k++) begin
          if (k < 4 || $urandom_range(7) == 0) begin
            value = ($urandom_range(3) == 0) ? 0 : 8'h41 + $urandom_range(2);
            send_beat(OP_LOAD_BYTE, slot, k, value, rand_addr());
          end
        end
      end
      base = ($urandom_range(5) == 0) ? {IN_ADDR_W{1'b1}} - $urandom_range(8) : rand_addr();
      send_beat(OP_START_REGION, $urandom_range(7), $urandom_range(31), $urandom_range(255),
                base);
      n_scan = ($urandom_range(3) == 0) ? $urandom_range(30, 45) : $urandom_range(12, 28);
      repeat (n_scan) begin
        roll = $urandom_range(99);
        if (roll < 6) begin
          send_beat(op_e'($urandom_range(3)), $urandom_range(7), $urandom_range(31),
                    $urandom_range(255), rand_addr());
        end else if (roll < 10) begin
          send_beat(OP_SET_LENGTH, $urandom_range(7), $urandom_range(31),
                    $urandom_range(1, 5), rand_addr());
        end else begin
          roll = $urandom_range(99);
          if (roll < 85) value = 8'h41 + $urandom_range(2);
          else if (roll < 95) value = 8'h00;
          else value = $urandom_range(255);
          send_beat(OP_SCAN_BYTE, $urandom_range(7), $urandom_range(31), value, rand_addr());
        end
      end
      if ($urandom_range(3) == 0) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  // Receiver: random tready, or a counted hold-off when one is requested.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left--;
      end else begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Check each accepted match beat against the oldest prediction.
  initial begin
    match_t got;
    match_t want;
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) begin
        got = '{slot: m_tdata[SLOT_W-1:0],
                addr: m_tdata[SLOT_W +: IN_ADDR_W],
                last: m_tlast};
        if (due_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected match beat slot=%0d addr=%h last=%b",
                     got.slot, got.addr, got.last);
        end else begin
          want = due_matches.pop_front();
          matches_seen++;
          if (got.slot != want.slot || got.addr != want.addr || got.last != want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: match %0d expected slot=%0d addr=%h last=%b, got slot=%0d addr=%h last=%b",
                       matches_seen, want.slot, want.addr, want.last,
                       got.slot, got.addr, got.last);
          end
        end
      end
    end
  end

  // Watchdog: end the run when neither side moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
      else quiet++;
    end
    $display("ERROR: no beat moved for %0d cycles, %0d matches pending",
             STALL_LIMIT, due_matches.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int i;
    int k;
    rst_n          = 1'b0;
    s_valid        = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_LOAD_BYTE;
    beats_sent     = 0;
    regions_opened = 0;
    matches_seen   = 0;
    mismatches     = 0;
    hold_left      = 0;
    no_idle        = 1'b0;
    // shadow state matches the block's reset
    for (i = 0; i < SIG_SLOTS; i++) begin
      for (k = 0; k < SIG_LEN; k++) sig_byte[i][k] = 8'h00;
      sig_len[i] = '0;
      found[i]   = 1'b0;
    end
    for (i = 0; i < SIG_LEN - 1; i++) window[i] = 8'h00;
    seen      = 0;
    next_addr = '0;
    repeat (4) @(negedge clk_i);
    rst_n = 1'b1;

    test_scan_before_region();
    test_special_cases();
    test_backpressure();
    test_random_regions();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d beats over %0d regions, checked %0d match beats, %0d mismatches",
             beats_sent, regions_opened, matches_seen, mismatches);
    if (mismatches == 0 && due_matches.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/wbss_pkg.sv
rtl/wbss_front.sv
rtl/wbss_queue.sv
rtl/wbss_back.sv
rtl/wildcard_byte_signature_scanner.sv
verif/testbench.sv
